// ===== hw/rtl/timestamp_sec_nsec_alu_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Timestamp ALU assertion macros
// Shared concurrent assertion forms used by the timestamp ALU RTL.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_SEC_NSEC_ALU_UNIT_DEFINES_SVH
`define TIMESTAMP_SEC_NSEC_ALU_UNIT_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define TSALU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never hold out of reset.
`define TSALU_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/tsalu_pkg.sv =====
// ----------------------------------------------------------------------------
// Timestamp ALU package
// Operation codes, constants and stage record types of the timestamp ALU.
// ----------------------------------------------------------------------------
package tsalu_pkg;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } tsalu_mode_t;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [30:0] NSEC_MAX   = 31'd999999999;
    localparam logic [63:0] SIGN64     = 64'h8000_0000_0000_0000;
    // floor(2^62 / 1e9), the reciprocal used by the seconds split.
    localparam logic [32:0] NS_RECIP   = 33'd4611686018;
    localparam logic [31:0] NS_TWO_SEC = 32'd2000000000;

    // One operand after the seconds scaling.
    typedef struct packed {
        logic        sec_neg;
        logic [63:0] sec_ns;
        logic        nsec_neg;
        logic [30:0] nsec_mag;
    } tsalu_fold_t;

    // Record carried alongside the scalar divider.
    typedef struct packed {
        logic        is_div;
        logic        neg;
        logic [63:0] other;
        logic        ovf;
        logic        dz;
        logic        lt;
        logic        eq;
    } tsalu_side1_t;

    // Record carried alongside the seconds split.
    typedef struct packed {
        logic neg;
        logic ovf;
        logic dz;
        logic lt;
        logic eq;
    } tsalu_side2_t;

endpackage

// ===== hw/rtl/timestamp_sec_nsec_alu_unit.sv =====
// ----------------------------------------------------------------------------
// Timestamp ALU
// Signed seconds/nanoseconds timestamp arithmetic: add, subtract, multiply
// or divide by an unsigned scalar, with overflow, divide-by-zero and compare
// flags. The unit takes one beat per cycle, except while it is stalled as
// described below, and returns the results in order. It is built from
// 75 register stages: four stages in front fold and combine the operands, a
// 64-stage restoring divider pipeline divides by the scalar one quotient bit
// per stage, one stage forms the magnitude of the signed total, five stages
// split that total into seconds and nanoseconds by a reciprocal multiply
// followed by a remainder correction, and one output register holds the
// result. The whole pipeline moves as one; it stands still only while a
// result waits at the output and the downstream side holds m_tready low,
// and s_tready follows that.
// ----------------------------------------------------------------------------
`include "timestamp_sec_nsec_alu_unit_defines.svh"

module timestamp_sec_nsec_alu_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_sec[34:0], a_nsec[65:35], b_sec[100:66], b_nsec[131:101],
    // scalar[163:132], zero fill [167:164]
    input  logic [167:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_sec[34:0], res_nsec[65:35], zero fill [71:66]
    output logic [71:0]  m_tdata,
    // overflow[0], div_by_zero[1], a_less_b[2], a_equal_b[3]
    output logic [3:0]   m_tuser
);
    import tsalu_pkg::*;

    // Turns an exact sign and magnitude (bit 64 is carry) into a wrapped
    // 64-bit total, flagging when it leaves the signed range.
    function automatic logic [64:0] settle(input logic neg, input logic [64:0] mag);
        logic        ovf;
        logic [63:0] val;
        ovf = mag[64] || (!neg && mag[63]) || (neg && (mag[63:0] > SIGN64));
        val = neg ? (64'd0 - mag[63:0]) : mag[63:0];
        return {ovf, val};
    endfunction

    function automatic tsalu_fold_t prep(input logic [34:0] sec,
                                         input logic [30:0] nsec);
        tsalu_fold_t f;
        logic [34:0] smag;
        logic [64:0] prod;
        smag       = sec[34] ? (35'd0 - sec) : sec;
        prod       = smag * NS_PER_SEC;
        f.sec_neg  = sec[34];
        f.sec_ns   = prod[63:0];
        f.nsec_neg = nsec[30];
        f.nsec_mag = nsec[30] ? (31'd0 - nsec) : nsec;
        return f;
    endfunction

    function automatic logic [64:0] fold(input tsalu_fold_t f);
        logic [64:0] sum;
        logic [64:0] mag;
        logic        neg;
        sum = {1'b0, f.sec_ns} + {34'd0, f.nsec_mag};
        if (f.sec_neg == f.nsec_neg) begin
            mag = sum;
            neg = f.sec_neg;
        end else if (f.sec_ns >= {33'd0, f.nsec_mag}) begin
            mag = {1'b0, f.sec_ns - {33'd0, f.nsec_mag}};
            neg = f.sec_neg;
        end else begin
            mag = {1'b0, {33'd0, f.nsec_mag} - f.sec_ns};
            neg = f.nsec_neg;
        end
        if (mag == 65'd0) begin
            neg = 1'b0;
        end
        return settle(neg, mag);
    endfunction

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage 1: operand scaling.
    logic        v1_reg;
    tsalu_fold_t a1_reg, b1_reg;
    tsalu_mode_t mode1_reg;
    logic [31:0] scalar1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg      <= prep(s_tdata[34:0], s_tdata[65:35]);
            b1_reg      <= prep(s_tdata[100:66], s_tdata[131:101]);
            mode1_reg   <= tsalu_mode_t'(s_tuser);
            scalar1_reg <= s_tdata[163:132];
        end
    end

    // Stage 2: fold into wrapped nanosecond totals.
    logic        v2_reg;
    logic [63:0] ta2_reg, tb2_reg;
    logic        ovfa2_reg, ovfb2_reg;
    tsalu_mode_t mode2_reg;
    logic [31:0] scalar2_reg;
    logic [64:0] fa_next, fb_next;

    assign fa_next = fold(a1_reg);
    assign fb_next = fold(b1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ta2_reg     <= fa_next[63:0];
            ovfa2_reg   <= fa_next[64];
            tb2_reg     <= fb_next[63:0];
            ovfb2_reg   <= fb_next[64];
            mode2_reg   <= mode1_reg;
            scalar2_reg <= scalar1_reg;
        end
    end

    // Stage 3: add/subtract, compare, and partial products of |A| * scalar.
    logic        v3_reg;
    logic [63:0] as3_reg;
    logic        asovf3_reg;
    logic        lt3_reg, eq3_reg, neg3_reg, ovfa3_reg;
    logic [63:0] mag3_reg, lo3_reg, hi3_reg;
    tsalu_mode_t mode3_reg;
    logic [31:0] scalar3_reg;
    logic [63:0] add_next, sub_next, mag_next;
    logic        add_ovf_next, sub_ovf_next;

    assign add_next     = ta2_reg + tb2_reg;
    assign sub_next     = ta2_reg - tb2_reg;
    assign add_ovf_next = ~(ta2_reg[63] ^ tb2_reg[63]) & (ta2_reg[63] ^ add_next[63]);
    assign sub_ovf_next = (ta2_reg[63] ^ tb2_reg[63]) & (ta2_reg[63] ^ sub_next[63]);
    assign mag_next     = ta2_reg[63] ? (64'd0 - ta2_reg) : ta2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (mode2_reg == MODE_SUB) begin
                as3_reg    <= sub_next;
                asovf3_reg <= ovfa2_reg || ovfb2_reg || sub_ovf_next;
            end else begin
                as3_reg    <= add_next;
                asovf3_reg <= ovfa2_reg || ovfb2_reg || add_ovf_next;
            end
            lt3_reg     <= $signed(ta2_reg) < $signed(tb2_reg);
            eq3_reg     <= ta2_reg == tb2_reg;
            neg3_reg    <= ta2_reg[63];
            ovfa3_reg   <= ovfa2_reg;
            mag3_reg    <= mag_next;
            lo3_reg     <= mag_next[31:0] * scalar2_reg;
            hi3_reg     <= mag_next[63:32] * scalar2_reg;
            mode3_reg   <= mode2_reg;
            scalar3_reg <= scalar2_reg;
        end
    end

    // Stage 4: finish the product and select what goes to the divider.
    logic         v4_reg;
    logic [63:0]  num4_reg;
    logic [31:0]  div4_reg;
    tsalu_side1_t side4_reg;
    logic [64:0]  hi_sum;
    logic [64:0]  prod_mag;
    logic         prod_neg;
    logic [64:0]  prod_res;
    tsalu_side1_t side4_next;

    assign hi_sum   = {1'b0, hi3_reg} + {33'd0, lo3_reg[63:32]};
    assign prod_mag = {|hi_sum[64:32], hi_sum[31:0], lo3_reg[31:0]};
    assign prod_neg = neg3_reg && (prod_mag != 65'd0);
    assign prod_res = settle(prod_neg, prod_mag);

    always_comb begin
        side4_next        = '0;
        side4_next.neg    = neg3_reg;
        side4_next.lt     = lt3_reg;
        side4_next.eq     = eq3_reg;
        case (mode3_reg)
            MODE_ADD, MODE_SUB: begin
                side4_next.other = as3_reg;
                side4_next.ovf   = asovf3_reg;
            end
            MODE_MUL: begin
                side4_next.other = prod_res[63:0];
                side4_next.ovf   = ovfa3_reg || prod_res[64];
            end
            MODE_DIV: begin
                side4_next.is_div = 1'b1;
                side4_next.dz     = scalar3_reg == 32'd0;
                side4_next.ovf    = ovfa3_reg && (scalar3_reg != 32'd0);
            end
            default: begin
                side4_next.other = as3_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num4_reg  <= mag3_reg;
            div4_reg  <= scalar3_reg;
            side4_reg <= side4_next;
        end
    end

    // Division of |A| by the scalar.
    logic         d1_valid;
    logic [63:0]  d1_quo;
    logic [31:0]  d1_rem;
    logic [$bits(tsalu_side1_t)-1:0] d1_side_bits;
    tsalu_side1_t d1_side;

    tsalu_div_pipe #(
        .WIDTH  (64),
        .DIV_W  (32),
        .SIDE_W ($bits(tsalu_side1_t))
    ) u_scalar_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .in_num    (num4_reg),
        .in_div    (div4_reg),
        .in_side   (side4_reg),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_rem   (d1_rem),
        .out_side  (d1_side_bits)
    );

    assign d1_side = tsalu_side1_t'(d1_side_bits);

    // Stage 5: signed result total, then its magnitude for the seconds split.
    logic         v5_reg;
    logic [63:0]  num5_reg;
    tsalu_side2_t side5_reg;
    logic [63:0]  total_next;
    logic         unused_rem;

    assign unused_rem = ^d1_rem;

    always_comb begin
        if (d1_side.is_div) begin
            total_next = d1_side.neg ? (64'd0 - d1_quo) : d1_quo;
        end else begin
            total_next = d1_side.other;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num5_reg      <= total_next[63] ? (64'd0 - total_next) : total_next;
            side5_reg.neg <= total_next[63] && !unused_rem | total_next[63];
            side5_reg.ovf <= d1_side.ovf;
            side5_reg.dz  <= d1_side.dz;
            side5_reg.lt  <= d1_side.lt;
            side5_reg.eq  <= d1_side.eq;
        end
    end

    // Split of the magnitude (at most 2^63) into seconds and nanoseconds.
    // The quotient estimate is ((|total| >> 30) * floor(2^62 / 1e9)) >> 32.
    // It never exceeds the true quotient and falls short of it by at most
    // two, so the remainder left after the estimate is below three seconds
    // and one compare-and-subtract step finishes the split.
    logic         v6_reg, v7_reg, v8_reg, v9_reg, v10_reg;
    logic [49:0]  plo6_reg, phi6_reg;
    logic [31:0]  x6_reg, x7_reg, x8_reg;
    logic [33:0]  q7_reg, q8_reg, q9_reg, q10_reg;
    logic [31:0]  qm8_reg, r9_reg, rem10_reg;
    tsalu_side2_t side6_reg, side7_reg, side8_reg, side9_reg, side10_reg;
    logic [65:0]  est_next;

    assign est_next = {16'd0, plo6_reg} + {phi6_reg[48:0], 17'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end else if (en) begin
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Stage 6: the shifted total in two 17-bit halves times the
            // reciprocal.
            plo6_reg   <= num5_reg[46:30] * NS_RECIP;
            phi6_reg   <= num5_reg[63:47] * NS_RECIP;
            x6_reg     <= num5_reg[31:0];
            side6_reg  <= side5_reg;
            // Stage 7: quotient estimate.
            q7_reg     <= est_next[65:32];
            x7_reg     <= x6_reg;
            side7_reg  <= side6_reg;
            // Stage 8: low word of estimate * 1e9; the remainder fits there.
            qm8_reg    <= 32'(q7_reg[31:0] * NS_PER_SEC);
            q8_reg     <= q7_reg;
            x8_reg     <= x7_reg;
            side8_reg  <= side7_reg;
            // Stage 9: remainder left by the estimate.
            r9_reg     <= x8_reg - qm8_reg;
            q9_reg     <= q8_reg;
            side9_reg  <= side8_reg;
            // Stage 10: bring the remainder below one second.
            if (r9_reg >= NS_TWO_SEC) begin
                q10_reg   <= q9_reg + 34'd2;
                rem10_reg <= r9_reg - NS_TWO_SEC;
            end else if (r9_reg >= 32'(NS_PER_SEC)) begin
                q10_reg   <= q9_reg + 34'd1;
                rem10_reg <= r9_reg - 32'(NS_PER_SEC);
            end else begin
                q10_reg   <= q9_reg;
                rem10_reg <= r9_reg;
            end
            side10_reg <= side9_reg;
        end
    end

    // Output register.
    logic        m_tvalid_reg;
    logic [34:0] res_sec_reg;
    logic [30:0] res_nsec_reg;
    logic [3:0]  flags_reg;
    logic [34:0] sec_signed;
    logic [30:0] nsec_signed;

    assign sec_signed  = side10_reg.neg ? (35'd0 - {1'b0, q10_reg}) : {1'b0, q10_reg};
    assign nsec_signed = side10_reg.neg ? (31'd0 - rem10_reg[30:0]) : rem10_reg[30:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= v10_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (side10_reg.dz) begin
                res_sec_reg  <= 35'd0;
                res_nsec_reg <= NSEC_MAX;
            end else begin
                res_sec_reg  <= sec_signed;
                res_nsec_reg <= nsec_signed;
            end
            flags_reg <= {side10_reg.eq, side10_reg.lt, side10_reg.dz, side10_reg.ovf};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, res_nsec_reg, res_sec_reg};
    assign m_tuser  = flags_reg;

    // A divide by zero reports a fixed result and never an overflow.
    `TSALU_ASSERT_IMPLY(a_dz_result, aclk, aresetn, m_tvalid && m_tuser[1], !m_tuser[0] && m_tdata[34:0] == 35'd0 && m_tdata[65:35] == NSEC_MAX, "divide by zero result wrong")
    // The two compare flags exclude each other.
    `TSALU_ASSERT_NEVER(a_cmp_excl, aclk, aresetn, m_tvalid && m_tuser[2] && m_tuser[3], "a_less_b and a_equal_b both set")
    // Seconds and nanoseconds never carry opposite signs.
    `TSALU_ASSERT_IMPLY(a_sign_agree, aclk, aresetn, m_tvalid && !m_tuser[1] && m_tdata[34:0] != 35'd0 && m_tdata[65:35] != 31'd0, m_tdata[34] == m_tdata[65], "result parts differ in sign")
    // The seconds split leaves a remainder below one second.
    `TSALU_ASSERT_IMPLY(a_rem_range, aclk, aresetn, v10_reg, rem10_reg < 32'(NS_PER_SEC), "nanosecond remainder out of range")

endmodule

// ===== hw/rtl/tsalu_div_pipe.sv =====
// ----------------------------------------------------------------------------
// Timestamp ALU divider pipeline
// Restoring unsigned division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module tsalu_div_pipe #(
    parameter int WIDTH  = 64,
    parameter int DIV_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [WIDTH-1:0]  in_num,
    input  logic [DIV_W-1:0]  in_div,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [WIDTH-1:0]  out_quo,
    output logic [DIV_W-1:0]  out_rem,
    output logic [SIDE_W-1:0] out_side
);

    // The dividend register shifts left one bit a stage and takes the new
    // quotient bit at the bottom, so it ends up holding the quotient.
    logic              valid_reg [WIDTH];
    logic [WIDTH-1:0]  num_reg   [WIDTH];
    logic [DIV_W-1:0]  rem_reg   [WIDTH];
    logic [DIV_W-1:0]  div_reg   [WIDTH];
    logic [SIDE_W-1:0] side_reg  [WIDTH];

    for (genvar i = 0; i < WIDTH; i++) begin : g_stage
        logic              prev_valid;
        logic [WIDTH-1:0]  prev_num;
        logic [DIV_W-1:0]  prev_rem;
        logic [DIV_W-1:0]  prev_div;
        logic [SIDE_W-1:0] prev_side;
        logic [DIV_W:0]    trial;
        logic [DIV_W:0]    diff;
        logic              ge;
        logic [WIDTH-1:0]  num_next;
        logic [DIV_W-1:0]  rem_next;

        if (i == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_num   = in_num;
            assign prev_rem   = '0;
            assign prev_div   = in_div;
            assign prev_side  = in_side;
        end else begin : g_rest
            assign prev_valid = valid_reg[i-1];
            assign prev_num   = num_reg[i-1];
            assign prev_rem   = rem_reg[i-1];
            assign prev_div   = div_reg[i-1];
            assign prev_side  = side_reg[i-1];
        end

        assign trial    = {prev_rem, prev_num[WIDTH-1]};
        assign ge       = trial >= {1'b0, prev_div};
        assign diff     = trial - {1'b0, prev_div};
        assign rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        assign num_next = {prev_num[WIDTH-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= prev_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[i]  <= num_next;
                rem_reg[i]  <= rem_next;
                div_reg[i]  <= prev_div;
                side_reg[i] <= prev_side;
            end
        end
    end

    assign out_valid = valid_reg[WIDTH-1];
    assign out_quo   = num_reg[WIDTH-1];
    assign out_rem   = rem_reg[WIDTH-1];
    assign out_side  = side_reg[WIDTH-1];

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Timestamp ALU testbench
// Drives seconds/nanoseconds operand pairs with all four modes into the
// timestamp ALU, predicts each result with a behavioral model of the
// timestamp arithmetic, and checks every output beat in order. Both stream
// sides idle at random, except in the final stretch of the run.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tsalu_pkg::*;

    localparam longint unsigned NSEC = 64'd1000000000;
    localparam longint SEC_MAX = 64'sd9223372036;
    localparam int LATENCY = 74;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [34:0] sec;
        logic [30:0] nsec;
        logic        ovf;
        logic        dz;
        logic        lt;
        logic        eq;
    } ts_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata = '0;
    logic [1:0]   s_tuser = MODE_ADD;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic [3:0]   m_tuser;

    ts_result_t expected_results[$];
    int  errors = 0;
    int  cycles = 0;
    // When set, neither side inserts idle cycles.
    bit  steady = 1'b0;

    timestamp_sec_nsec_alu_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #6 aclk = ~aclk;

    // Fold seconds and nanoseconds into a 64-bit nanosecond total. The exact
    // value is formed at 128 bits, so any departure from the signed 64-bit
    // range shows up in the upper half.
    function automatic logic [63:0] fold_total(logic [34:0] sec, logic [30:0] nsec,
                                               output bit out_of_range);
        logic signed [127:0] exact;
        exact = 128'(signed'(sec)) * 128'sd1000000000 + 128'(signed'(nsec));
        out_of_range = (exact > 128'sh7FFF_FFFF_FFFF_FFFF) ||
                       (exact < -128'sh8000_0000_0000_0000);
        return exact[63:0];
    endfunction

    // Work out the result beat for one operation.
    function automatic ts_result_t timestamp_alu(tsalu_mode_t mode,
            logic [34:0] as, logic [30:0] an, logic [34:0] bs, logic [30:0] bn,
            logic [31:0] scalar);
        ts_result_t res;
        bit oa, ob;
        logic [63:0] ta, tb, total, mag, q, m;
        logic signed [127:0] exact;
        bit neg;
        ta = fold_total(as, an, oa);
        tb = fold_total(bs, bn, ob);
        res = '0;
        res.lt = $signed(ta) < $signed(tb);
        res.eq = ta == tb;
        total = '0;
        case (mode)
            MODE_ADD: begin
                exact = 128'($signed(ta)) + 128'($signed(tb));
                total = exact[63:0];
                res.ovf = oa || ob || (exact != 128'($signed(total)));
            end
            MODE_SUB: begin
                exact = 128'($signed(ta)) - 128'($signed(tb));
                total = exact[63:0];
                res.ovf = oa || ob || (exact != 128'($signed(total)));
            end
            MODE_MUL: begin
                exact = 128'($signed(ta)) * $signed({96'd0, scalar});
                total = exact[63:0];
                res.ovf = oa || (exact != 128'($signed(total)));
            end
            default: begin
                if (scalar == 0) begin
                    res.dz = 1'b1;
                end else begin
                    // The magnitude of the most negative total is 2^63, which
                    // an unsigned 64-bit value still holds.
                    neg = ta[63];
                    mag = neg ? -ta : ta;
                    q = mag / {32'd0, scalar};
                    total = neg ? -q : q;
                    res.ovf = oa;
                end
            end
        endcase
        if (res.dz) begin
            res.sec = '0;
            res.nsec = NSEC_MAX;
        end else begin
            neg = total[63];
            mag = neg ? -total : total;
            q = mag / NSEC;
            m = mag % NSEC;
            q = neg ? -q : q;
            m = neg ? -m : m;
            res.sec = q[34:0];
            res.nsec = m[30:0];
        end
        return res;
    endfunction

    // Random idle stretches on the input side, unless the run is steady.
    task automatic idle_gap();
        if (!steady && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // Offer one beat and hold it until the unit accepts it.
    task automatic send_op(tsalu_mode_t mode, logic [34:0] as, logic [30:0] an,
                           logic [34:0] bs, logic [30:0] bn, logic [31:0] scalar);
        expected_results.push_back(timestamp_alu(mode, as, an, bs, bn, scalar));
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'd0, scalar, bn, bs, an, as};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (!steady && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic finish_sending();
        s_tvalid <= 1'b0;
    endtask

    // Sink side: random backpressure and the per-beat comparison.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady ? 1'b1 : ($urandom_range(0, 4) != 0);
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat sec=%0d nsec=%0d", $time,
                             $signed(m_tdata[34:0]), $signed(m_tdata[65:35]));
                    errors++;
                end else begin
                    automatic ts_result_t want = expected_results.pop_front();
                    if (m_tdata[34:0] !== want.sec) begin
                        $display("%0t: res_sec expected %0d actual %0d", $time,
                                 $signed(want.sec), $signed(m_tdata[34:0]));
                        errors++;
                    end
                    if (m_tdata[65:35] !== want.nsec) begin
                        $display("%0t: res_nsec expected %0d actual %0d", $time,
                                 $signed(want.nsec), $signed(m_tdata[65:35]));
                        errors++;
                    end
                    if (m_tuser !== {want.eq, want.lt, want.dz, want.ovf}) begin
                        $display("%0t: flags {eq,lt,dz,ovf} expected %b actual %b",
                                 $time, {want.eq, want.lt, want.dz, want.ovf}, m_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog for a hung pipeline.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** timestamp_sec_nsec_alu_unit: FAILED **");
            $finish;
        end
    end

    function automatic logic [34:0] rand_sec();
        case ($urandom_range(0, 3))
            0: return 35'($signed($urandom_range(0, 20)) - 10);
            1: return 35'(longint'($urandom_range(0, 2000000000)) - 1000000000);
            2: return 35'({$urandom, $urandom});
            default: return 35'($urandom_range(0, 1) ? SEC_MAX : -SEC_MAX);
        endcase
    endfunction

    function automatic logic [30:0] rand_nsec();
        case ($urandom_range(0, 3))
            0: return 31'(longint'($urandom_range(0, 1999999998)) - 999999999);
            1: return 31'($urandom);
            2: return $urandom_range(0, 1) ? NSEC_MAX : -NSEC_MAX;
            default: return 31'($signed($urandom_range(0, 4)) - 2);
        endcase
    endfunction

    function automatic logic [31:0] rand_scalar();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 4);
            1: return $urandom;
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 3000);
        endcase
    endfunction

    // Extremes of every field through each mode.
    task automatic test_extremes();
        send_op(MODE_ADD, 35'(SEC_MAX), NSEC_MAX, 35'(SEC_MAX), NSEC_MAX, 0);
        send_op(MODE_ADD, 35'(-SEC_MAX), -NSEC_MAX, 35'(-SEC_MAX), -NSEC_MAX, 0);
        send_op(MODE_SUB, 35'(SEC_MAX), NSEC_MAX, 35'(-SEC_MAX), -NSEC_MAX, '1);
        send_op(MODE_SUB, 0, 0, 0, 0, 0);
        send_op(MODE_ADD, 1, -NSEC_MAX, -1, NSEC_MAX, 0);
        send_op(MODE_SUB, 5, 0, 5, 0, 7);
        send_op(MODE_MUL, 35'(SEC_MAX), NSEC_MAX, 0, 0, '1);
        send_op(MODE_MUL, 35'(-SEC_MAX), -NSEC_MAX, 1, 1, 2);
        send_op(MODE_DIV, 35'(-SEC_MAX), -NSEC_MAX, 0, 0, '1);
        send_op(MODE_DIV, 35'(SEC_MAX), NSEC_MAX, 0, 0, 1);
    endtask

    // Multiply by zero, divide by zero, and raw field patterns beyond range.
    task automatic test_special_cases();
        send_op(MODE_MUL, 35'(-7), -5, 3, 3, 0);
        send_op(MODE_DIV, 12, 34, 12, 34, 0);
        send_op(MODE_DIV, 35'(-3), -1, 0, 0, 0);
        send_op(MODE_ADD, '1, '1, 35'h4_0000_0000, 31'h4000_0000, 0);
        send_op(MODE_SUB, 35'h3_FFFF_FFFF, 31'h3FFF_FFFF, 0, 0, 0);
        send_op(MODE_MUL, 35'h4_0000_0000, 31'h4000_0000, 0, 0, 1);
        send_op(MODE_DIV, 35'h3_FFFF_FFFF, 31'h3FFF_FFFF, '1, '1, 3);
        send_op(MODE_MUL, 0, 1, 0, 2, 32'hFFFF_FFFF);
        send_op(MODE_ADD, 0, -1, 0, 1, 0);
    endtask

    task automatic test_random_ops(int count);
        for (int i = 0; i < count; i++) begin
            if (i == count - 60) steady = 1'b1;
            idle_gap();
            send_op(tsalu_mode_t'($urandom_range(0, 3)), rand_sec(), rand_nsec(),
                    rand_sec(), rand_nsec(), rand_scalar());
        end
        finish_sending();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_special_cases();
        test_random_ops(530);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (errors == 0)
            $display("** timestamp_sec_nsec_alu_unit: PASSED **");
        else
            $display("** timestamp_sec_nsec_alu_unit: FAILED **");
        $finish;
    end
endmodule
